### rtl/core/arc_pkg.sv
// Shared types and constants for the adaptive repetition counter.
// No dependencies; imported by adaptive_rep_counter.
package arc_pkg;

   localparam int SAMPLE_BITS_DEFAULT    = 16;
   localparam int REP_COUNT_BITS_DEFAULT = 16;

   localparam int TARGET_BITS     = 8;
   localparam int SCALE_BITS      = 9;
   localparam int SCALE_FRAC_BITS = 8;
   localparam int CSR_INDEX_BITS  = 2;

   localparam int UP_RESET     = 4096;
   localparam int DOWN_RESET   = -4096;
   localparam int TARGET_RESET = 10;
   localparam int SCALE_RESET  = 179;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_UP_LEVEL   = 2'd0,
      CSR_DOWN_LEVEL = 2'd1,
      CSR_TARGET     = 2'd2,
      CSR_SCALE      = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      PHASE_CHOOSE = 2'd0,
      PHASE_TRAIN  = 2'd1,
      PHASE_COUNT  = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      AXIS_NONE = 2'd0,
      AXIS_X    = 2'd1,
      AXIS_Y    = 2'd2,
      AXIS_Z    = 2'd3
   } axis_type;

endpackage

### rtl/core/adaptive_rep_counter.sv
// Adaptive repetition counter: axis choice, hysteresis training, rep counting.
// Depends on arc_pkg for types, register indexes and reset values.
// An accepted word passes the input register and shows on rsp_ once it reaches the result register.
// Throughput: one word per cycle while rsp_ is not stalled; input register, one update stage, result register.
// A stalled result word holds the input register, which then stalls req_.
// Reset: synchronous, active high; clears all tracking state and loads register defaults.
module adaptive_rep_counter #(
   parameter int SAMPLE_BITS    = arc_pkg::SAMPLE_BITS_DEFAULT,
   parameter int REP_COUNT_BITS = arc_pkg::REP_COUNT_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write,
   input  logic [arc_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [((SAMPLE_BITS > arc_pkg::SCALE_BITS) ? SAMPLE_BITS
                  : arc_pkg::SCALE_BITS)-1:0]    csr_data,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [SAMPLE_BITS-1:0]         req_accel_x,
   input  logic signed [SAMPLE_BITS-1:0]         req_accel_y,
   input  logic signed [SAMPLE_BITS-1:0]         req_accel_z,
   input  logic                                  req_restart,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [1:0]                            rsp_phase,
   output logic [1:0]                            rsp_chosen_axis,
   output logic                                  rsp_moving_up,
   output logic [arc_pkg::TARGET_BITS-1:0]       rsp_training_done_count,
   output logic [REP_COUNT_BITS-1:0]             rsp_rep_total,
   output logic                                  rsp_rep_event,
   output logic signed [SAMPLE_BITS-1:0]         rsp_learned_up,
   output logic signed [SAMPLE_BITS-1:0]         rsp_learned_down
);
   import arc_pkg::*;

   localparam int PROD_BITS = SAMPLE_BITS + SCALE_BITS + 1;
   localparam int HEAD_BITS = PROD_BITS - SAMPLE_BITS + 1;

   // configuration
   logic signed [SAMPLE_BITS-1:0] up_level_ff;
   logic signed [SAMPLE_BITS-1:0] down_level_ff;
   logic [TARGET_BITS-1:0]        target_ff;
   logic [SCALE_BITS-1:0]         scale_ff;

   // input register
   logic                          in_valid_ff, in_valid_in;
   logic signed [SAMPLE_BITS-1:0] in_x_ff, in_y_ff, in_z_ff;
   logic                          in_restart_ff;

   // tracking state
   axis_type                      axis_ff, axis_in;
   logic                          up_ff, up_in;
   logic [TARGET_BITS-1:0]        train_ff, train_in;
   logic [REP_COUNT_BITS-1:0]     reps_ff, reps_in;
   logic signed [SAMPLE_BITS-1:0] peak_high_ff, peak_high_in;
   logic signed [SAMPLE_BITS-1:0] peak_low_ff, peak_low_in;
   logic signed [SAMPLE_BITS-1:0] learned_high_ff, learned_high_in;
   logic signed [SAMPLE_BITS-1:0] learned_low_ff, learned_low_in;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   phase_type                     rsp_phase_ff, phase_in;
   logic                          rsp_event_ff, event_in;

   logic                          out_free, fire, req_take;
   logic [SAMPLE_BITS-1:0]        mag_x, mag_y, mag_z;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic signed [SAMPLE_BITS-1:0] scaled_high, scaled_low;

   function automatic logic signed [SAMPLE_BITS-1:0] scale_sat(
      input logic signed [SAMPLE_BITS-1:0] peak,
      input logic [SCALE_BITS-1:0]         scale
   );
      logic signed [PROD_BITS-1:0] prod;
      logic signed [PROD_BITS-1:0] quot;
      logic [HEAD_BITS-1:0]        head;
      logic signed [SAMPLE_BITS-1:0] res;
      prod = PROD_BITS'(peak) * PROD_BITS'(signed'({1'b0, scale}));
      // truncate toward zero
      if (prod[PROD_BITS-1])
         quot = (prod + PROD_BITS'((1 << SCALE_FRAC_BITS) - 1)) >>> SCALE_FRAC_BITS;
      else
         quot = prod >>> SCALE_FRAC_BITS;
      head = quot[PROD_BITS-1:SAMPLE_BITS-1];
      if (head != '0 && head != '1)
         res = quot[PROD_BITS-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                 : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      else
         res = quot[SAMPLE_BITS-1:0];
      return res;
   endfunction

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = fire ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   assign mag_x = in_x_ff[SAMPLE_BITS-1] ? SAMPLE_BITS'(-in_x_ff) : in_x_ff;
   assign mag_y = in_y_ff[SAMPLE_BITS-1] ? SAMPLE_BITS'(-in_y_ff) : in_y_ff;
   assign mag_z = in_z_ff[SAMPLE_BITS-1] ? SAMPLE_BITS'(-in_z_ff) : in_z_ff;

   always_comb begin
      case (axis_ff)
         AXIS_X:  sample = in_x_ff;
         AXIS_Y:  sample = in_y_ff;
         default: sample = in_z_ff;
      endcase
   end

   always_comb begin
      axis_in         = axis_ff;
      up_in           = up_ff;
      train_in        = train_ff;
      reps_in         = reps_ff;
      peak_high_in    = peak_high_ff;
      peak_low_in     = peak_low_ff;
      learned_high_in = learned_high_ff;
      learned_low_in  = learned_low_ff;
      event_in        = 1'b0;
      scaled_high     = '0;
      scaled_low      = '0;

      if (in_restart_ff) begin
         if (train_ff != '0) begin
            axis_in         = AXIS_NONE;
            up_in           = 1'b0;
            train_in        = '0;
            reps_in         = '0;
            peak_high_in    = '0;
            peak_low_in     = '0;
            learned_high_in = '0;
            learned_low_in  = '0;
         end
      end else if (axis_ff == AXIS_NONE) begin
         if (mag_x > mag_y && mag_x > mag_z)
            axis_in = AXIS_X;
         else if (mag_y > mag_x && mag_y > mag_z)
            axis_in = AXIS_Y;
         else
            axis_in = AXIS_Z;
      end else if (train_ff < target_ff) begin
         if (sample > peak_high_ff) peak_high_in = sample;
         if (sample < peak_low_ff) peak_low_in = sample;
         if (sample > up_level_ff && !up_ff) begin
            up_in = 1'b1;
         end else if (sample < down_level_ff && up_ff) begin
            up_in    = 1'b0;
            train_in = train_ff + 1'b1;
            event_in = 1'b1;
         end
         scaled_high = scale_sat(peak_high_in, scale_ff);
         scaled_low  = scale_sat(peak_low_in, scale_ff);
         if (train_in == target_ff) begin
            learned_high_in = scaled_high;
            learned_low_in  = scaled_low;
         end
      end else begin
         if (sample > learned_high_ff && !up_ff) begin
            up_in = 1'b1;
         end else if (sample < learned_low_ff && up_ff) begin
            up_in    = 1'b0;
            event_in = 1'b1;
            if (reps_ff != '1) reps_in = reps_ff + 1'b1;
         end
      end

      if (axis_in == AXIS_NONE)
         phase_in = PHASE_CHOOSE;
      else if (train_in < target_ff)
         phase_in = PHASE_TRAIN;
      else
         phase_in = PHASE_COUNT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         up_level_ff   <= SAMPLE_BITS'(UP_RESET);
         down_level_ff <= SAMPLE_BITS'(DOWN_RESET);
         target_ff     <= TARGET_BITS'(TARGET_RESET);
         scale_ff      <= SCALE_BITS'(SCALE_RESET);
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_UP_LEVEL:   up_level_ff   <= csr_data[SAMPLE_BITS-1:0];
            CSR_DOWN_LEVEL: down_level_ff <= csr_data[SAMPLE_BITS-1:0];
            CSR_TARGET:     target_ff     <= csr_data[TARGET_BITS-1:0];
            CSR_SCALE:      scale_ff      <= csr_data[SCALE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_x_ff       <= req_accel_x;
         in_y_ff       <= req_accel_y;
         in_z_ff       <= req_accel_z;
         in_restart_ff <= req_restart;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff         <= AXIS_NONE;
         up_ff           <= 1'b0;
         train_ff        <= '0;
         reps_ff         <= '0;
         peak_high_ff    <= '0;
         peak_low_ff     <= '0;
         learned_high_ff <= '0;
         learned_low_ff  <= '0;
      end else if (fire) begin
         axis_ff         <= axis_in;
         up_ff           <= up_in;
         train_ff        <= train_in;
         reps_ff         <= reps_in;
         peak_high_ff    <= peak_high_in;
         peak_low_ff     <= peak_low_in;
         learned_high_ff <= learned_high_in;
         learned_low_ff  <= learned_low_in;
      end
   end

   // result word; the copied state fields follow the state registers
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_phase_ff <= phase_in;
         rsp_event_ff <= event_in;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_phase               = rsp_phase_ff;
   assign rsp_chosen_axis         = axis_ff;
   assign rsp_moving_up           = up_ff;
   assign rsp_training_done_count = train_ff;
   assign rsp_rep_total           = reps_ff;
   assign rsp_rep_event           = rsp_event_ff;
   assign rsp_learned_up          = learned_high_ff;
   assign rsp_learned_down        = learned_low_ff;

endmodule
